// ===== sv/tse_pkg.sv =====
// ----------------------------------------------------------------------------
// tse_pkg: shared types and codes for the topological sort engine
// Holds the item structs, op codes, queue entry and back-end state type.
// ----------------------------------------------------------------------------
`default_nettype none
package tse_pkg;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_SORT  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef struct packed {
    logic [1:0] op;
    logic [4:0] src_vertex;
    logic [4:0] dst_vertex;
  } in_item_t;

  typedef struct packed {
    logic [4:0] vertex;
    logic       vertex_valid;
    logic       last;
    logic       incomplete;
    logic       edges_dropped;
  } out_item_t;

  // command handed from front to back
  typedef enum logic [1:0] {
    CMD_ADD   = 2'd0,
    CMD_SORT  = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_DROP  = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t       cmd;
    logic [4:0] src;
    logic [4:0] dst;
  } cmd_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CNT,
    ST_SEED,
    ST_POP,
    ST_SCAN,
    ST_EMIT,
    ST_DONE
  } bk_state_t;

endpackage : tse_pkg
`default_nettype wire

// ===== sv/tse_ram.sv =====
// ----------------------------------------------------------------------------
// tse_ram: generic single-port-write, single-port-read RAM
// Registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module tse_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule : tse_ram
`default_nettype wire

// ===== sv/tse_front.sv =====
// ----------------------------------------------------------------------------
// tse_front: input stage
// Accepts items, classifies add edges as kept or dropped, and pushes
// commands into a two-entry queue toward the back end.
// ----------------------------------------------------------------------------
`default_nettype none
module tse_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic [5:0]         eff_count,
  input  wire logic               in_valid,
  output      logic               in_stall,
  input  wire tse_pkg::in_item_t  in_data,
  output      logic               q_valid,
  input  wire logic               q_pop,
  output      tse_pkg::cmd_item_t q_data
);
  import tse_pkg::*;

  cmd_item_t  q_r [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic       rd_r, rd_nxt;
  logic       push;
  cmd_item_t  cls;

  always_comb begin
    cls.src = in_data.src_vertex;
    cls.dst = in_data.dst_vertex;
    unique case (op_t'(in_data.op))
      OP_ADD: begin
        if ({1'b0, in_data.src_vertex} >= eff_count ||
            {1'b0, in_data.dst_vertex} >= eff_count) begin
          cls.cmd = CMD_DROP;
        end else begin
          cls.cmd = CMD_ADD;
        end
      end
      OP_SORT:  cls.cmd = CMD_SORT;
      OP_CLEAR: cls.cmd = CMD_CLEAR;
      default:  cls.cmd = CMD_ADD;
    endcase
  end

  assign in_stall = (cnt_r == 2'd2);
  // op 3 is swallowed here
  assign push     = in_valid && !in_stall && (op_t'(in_data.op) != OP_NONE);
  assign q_valid  = (cnt_r != 2'd0);
  assign q_data   = q_r[rd_r];

  always_comb begin
    cnt_nxt = cnt_r + 2'(push) - 2'(q_pop);
    rd_nxt  = rd_r ^ q_pop;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      rd_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      rd_r  <= rd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[rd_r ^ cnt_r[0]] <= cls;
    end
  end
endmodule : tse_front
`default_nettype wire

// ===== sv/tse_back.sv =====
// ----------------------------------------------------------------------------
// tse_back: execution stage
// Stores edges, and for a sort counts in-degrees, seeds the ready queue and
// walks the edge store once per emitted vertex.
// ----------------------------------------------------------------------------
`default_nettype none
module tse_back #(
  parameter int MAX_VERTICES = 32,
  parameter int MAX_EDGES    = 256
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic [5:0]         eff_count,
  input  wire logic               q_valid,
  output      logic               q_pop,
  input  wire tse_pkg::cmd_item_t q_data,
  output      logic               out_valid,
  input  wire logic               out_stall,
  output      tse_pkg::out_item_t out_data
);
  import tse_pkg::*;

  localparam int NV = (MAX_VERTICES < 32) ? MAX_VERTICES : 32;
  localparam int EW = $clog2(MAX_EDGES);
  localparam int TW = $clog2(MAX_EDGES + 1);
  localparam int VW = $clog2(NV);
  localparam int DW = TW;

  bk_state_t st_r, st_nxt;
  logic [TW-1:0] total_r;
  logic          drop_r;
  logic [EW-1:0] eidx_r;
  logic          rvld_r;
  logic [TW-1:0] scnt_r;
  logic [DW-1:0] deg_r [NV];
  logic [4:0]    rq_r [32];
  logic [5:0]    head_r, tail_r, seed_r;
  logic [4:0]    cur_r;
  logic          ov_r, ov_nxt;
  out_item_t     ob_r, ob_nxt;
  logic          ob_load;
  logic          hold_r;
  out_item_t     hold_item_r;

  logic          we;
  logic [9:0]    rdata;
  logic [EW-1:0] raddr;
  logic          scan_end;
  logic          rd_issue;
  logic [4:0]    es, ed;
  logic          e_ok;

  assign we = (st_r == ST_IDLE) && q_valid && q_data.cmd == CMD_ADD &&
              total_r != TW'(MAX_EDGES);

  tse_ram #(.WIDTH(10), .DEPTH(MAX_EDGES)) u_edges (
    .clk   (clk),
    .we    (we),
    .waddr (total_r[EW-1:0]),
    .wdata ({q_data.src, q_data.dst}),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign es   = rdata[9:5];
  assign ed   = rdata[4:0];
  assign e_ok = ({1'b0, es} < eff_count) && ({1'b0, ed} < eff_count);
  // issue reads while the issue count lags total
  assign raddr    = eidx_r;
  assign scan_end = (scnt_r == total_r);

  // output register free when empty or when out_stall is low
  logic ob_free;
  assign ob_free = !ov_r || !out_stall;

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE: if (q_valid && q_data.cmd == CMD_SORT) st_nxt = ST_CNT;
      ST_CNT:  if (scan_end && !rvld_r) st_nxt = ST_SEED;
      ST_SEED: if (seed_r == eff_count) st_nxt = ST_POP;
      ST_POP:  if (ob_free) st_nxt = (head_r == tail_r) ? ST_DONE : ST_SCAN;
      ST_SCAN: if (scan_end && !rvld_r) st_nxt = ST_POP;
      ST_DONE: if (ob_free) st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    q_pop = (st_r == ST_IDLE) && q_valid && (q_data.cmd != CMD_SORT ||
                                             st_nxt == ST_CNT);
  end

  // flush the held vertex once we know whether it is the last
  always_comb begin
    ob_nxt            = hold_item_r;
    ob_nxt.last       = (head_r == tail_r);
    ob_nxt.incomplete = (head_r == tail_r) && (head_r < eff_count);
    if (st_r == ST_DONE) begin
      ob_nxt = '{vertex: 5'd0, vertex_valid: 1'b0, last: 1'b1,
                 incomplete: (eff_count != 6'd0), edges_dropped: drop_r};
    end
  end

  assign ob_load  = ob_free && ((st_r == ST_POP && hold_r) ||
                                (st_r == ST_DONE && head_r == 6'd0));
  assign ov_nxt   = ob_load || (ov_r && out_stall);
  assign rd_issue = (st_r == ST_CNT || st_r == ST_SCAN) && (issued_r != total_r);

  assign out_valid = ov_r;
  assign out_data  = ob_r;

  logic [TW-1:0] issued_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= ST_IDLE;
      total_r <= '0;
      drop_r  <= 1'b0;
      ov_r    <= 1'b0;
      hold_r  <= 1'b0;
      rvld_r  <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      ov_r   <= ov_nxt;
      rvld_r <= rd_issue;
      if (ob_load) ob_r <= ob_nxt;
      unique case (st_r)
        ST_IDLE: begin
          if (q_valid) begin
            unique case (q_data.cmd)
              CMD_ADD:   if (we) total_r <= total_r + 1'b1; else drop_r <= 1'b1;
              CMD_DROP:  drop_r <= 1'b1;
              CMD_CLEAR: begin total_r <= '0; drop_r <= 1'b0; end
              default: begin
                issued_r <= '0;
                scnt_r   <= '0;
                eidx_r   <= '0;
                for (int i = 0; i < NV; i++) deg_r[i] <= '0;
              end
            endcase
          end
        end
        ST_CNT, ST_SCAN: begin
          if (rd_issue) begin
            issued_r <= issued_r + 1'b1;
            eidx_r   <= eidx_r + 1'b1;
          end
          if (rvld_r) begin
            scnt_r <= scnt_r + 1'b1;
            if (st_r == ST_CNT) begin
              if (e_ok) deg_r[ed[VW-1:0]] <= deg_r[ed[VW-1:0]] + 1'b1;
            end else if (es == cur_r && ({1'b0, ed} < eff_count) &&
                         deg_r[ed[VW-1:0]] != '0) begin
              deg_r[ed[VW-1:0]] <= deg_r[ed[VW-1:0]] - 1'b1;
              if (deg_r[ed[VW-1:0]] == DW'(1) && tail_r < 6'd32) begin
                rq_r[tail_r[4:0]] <= ed;
                tail_r <= tail_r + 1'b1;
              end
            end
          end
          if (st_nxt == ST_SEED) begin
            seed_r <= '0;
            head_r <= '0;
            tail_r <= '0;
          end
        end
        ST_SEED: begin
          if (seed_r != eff_count) begin
            if (deg_r[seed_r[VW-1:0]] == '0) begin
              rq_r[tail_r[4:0]] <= seed_r[4:0];
              tail_r <= tail_r + 1'b1;
            end
            seed_r <= seed_r + 1'b1;
          end
        end
        ST_POP: begin
          if (ob_free) begin
            hold_r <= (head_r != tail_r);
            if (head_r != tail_r) begin
              cur_r <= rq_r[head_r[4:0]];
              hold_item_r <= '{vertex: rq_r[head_r[4:0]], vertex_valid: 1'b1,
                               last: 1'b0, incomplete: 1'b0,
                               edges_dropped: drop_r};
              head_r <= head_r + 1'b1;
              issued_r <= '0;
              scnt_r <= '0;
              eidx_r <= '0;
            end
          end
        end
        default: ;
      endcase
    end
  end
endmodule : tse_back
`default_nettype wire

// ===== sv/topological_sort_engine.sv =====
// ----------------------------------------------------------------------------
// topological_sort_engine: Kahn topological sort over a loaded edge list
//
// Usage: write cfg_vertex_count (while idle) with the vertex count. Send
// items on in_*: op 0 adds an edge, op 2 clears all edges and the drop flag,
// op 1 runs a sort. Add and clear give no result; a sort gives one result
// per sorted vertex on out_*, the final one marked last with incomplete set
// if a cycle left vertices unsorted. If nothing sorts, a single marker with
// vertex_valid low is given.
// Adds pass through a two-entry command queue that decouples the front end
// from the back end. A sort counts degrees and seeds the queue, then scans
// every stored edge once per sorted vertex through the single read port of
// the edge RAM. Each vertex leaves after its own edge scan.
// Reset clears the edge count, drop flag and queue; vertex count returns to
// 32. When out_stall is high the result holds and the sort pauses.
// ----------------------------------------------------------------------------
`default_nettype none
module topological_sort_engine #(
  parameter int MAX_VERTICES = 32,
  parameter int MAX_EDGES    = 256
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [5:0]         cfg_vertex_count,
  input  wire logic               in_valid,
  output      logic               in_stall,
  input  wire tse_pkg::in_item_t  in_data,
  output      logic               out_valid,
  input  wire logic               out_stall,
  output      tse_pkg::out_item_t out_data
);
  import tse_pkg::*;

  localparam int LIM = (MAX_VERTICES < 32) ? MAX_VERTICES : 32;

  logic [5:0] vc_r, eff;
  logic       q_valid, q_pop;
  cmd_item_t  q_data;

  // hold configured count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= 6'd32;
    end else if (cfg_we) begin
      vc_r <= cfg_vertex_count;
    end
  end

  // saturate to what the queue and result limit allow
  assign eff = (vc_r > 6'(LIM)) ? 6'(LIM) : vc_r;

  tse_front u_front (
    .clk(clk), .rst_n(rst_n), .eff_count(eff),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .q_valid(q_valid), .q_pop(q_pop), .q_data(q_data)
  );

  tse_back #(.MAX_VERTICES(MAX_VERTICES), .MAX_EDGES(MAX_EDGES)) u_back (
    .clk(clk), .rst_n(rst_n), .eff_count(eff),
    .q_valid(q_valid), .q_pop(q_pop), .q_data(q_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );
endmodule : topological_sort_engine
`default_nettype wire

// ===== sv/tse_checker.sv =====
// ----------------------------------------------------------------------------
// tse_checker: port-level checks for the topological sort engine
// Bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
module tse_checker (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire tse_pkg::out_item_t out_data
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");
  a_marker_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.vertex_valid |-> out_data.last)
    else $error("empty marker without last");
  a_inc_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.incomplete |-> out_data.last)
    else $error("incomplete before last");
endmodule : tse_checker

bind topological_sort_engine tse_checker u_chk (
  .clk(clk), .rst_n(rst_n), .out_valid(out_valid),
  .out_stall(out_stall), .out_data(out_data)
);
`default_nettype wire

// ===== test/topological_sort_engine_test.sv =====
// ----------------------------------------------------------------------------
// topological_sort_engine_test: self-checking bench for the sort engine
// Loads edge lists, runs sorts and compares every result item with a
// predictor of Kahn's algorithm kept inside the bench, under random idling.
// ----------------------------------------------------------------------------
`default_nettype none
module topological_sort_engine_test;
  timeunit 1ns;
  timeprecision 1ps;
  import tse_pkg::*;

  localparam int VMAX = 32;
  localparam int EMAX = 256;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [5:0] cfg_vertex_count = 6'd32;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;

  topological_sort_engine u_dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_vertex_count(cfg_vertex_count),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  // Predictor state: mirror of the graph held by the block.
  logic [9:0] graph_edges [EMAX];
  int unsigned edge_cnt = 0;
  logic dropped = 1'b0;
  logic [5:0] vcount = 6'd32;

  in_item_t pending_items[$];
  out_item_t expected_order[$];
  int errors = 0;
  int items_sent = 0;
  int results_seen = 0;
  int sorts_run = 0;
  bit send_enable = 1'b0;

  task automatic report(input string what, input out_item_t got, input out_item_t want);
    $display("mismatch %0s: got %h want %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic out_item_t mk(input int v, input bit ok, input bit lst, input bit inc);
    out_item_t r;
    r.vertex = v[4:0];
    r.vertex_valid = ok;
    r.last = lst;
    r.incomplete = inc;
    r.edges_dropped = dropped;
    return r;
  endfunction

  // Kahn's sort over the mirrored store; appends the expected items.
  task automatic predict_sort();
    int unsigned n, head, tail, u, s, d;
    int unsigned indeg [VMAX];
    int unsigned order [VMAX];
    n = (vcount > VMAX) ? VMAX : vcount;
    head = 0;
    tail = 0;
    for (int i = 0; i < VMAX; i++) indeg[i] = 0;
    for (int e = 0; e < edge_cnt; e++) begin
      s = graph_edges[e][9:5];
      d = graph_edges[e][4:0];
      if (s < n && d < n) indeg[d]++;
    end
    for (int i = 0; i < n; i++) if (indeg[i] == 0) order[tail++] = i;
    while (head < tail) begin
      u = order[head++];
      for (int e = 0; e < edge_cnt; e++) begin
        s = graph_edges[e][9:5];
        d = graph_edges[e][4:0];
        if (s != u || d >= n) continue;
        if (indeg[d] > 0) begin
          indeg[d]--;
          if (indeg[d] == 0 && tail < VMAX) order[tail++] = d;
        end
      end
    end
    if (head == 0) begin
      expected_order = {expected_order, mk(0, 1'b0, 1'b1, n > 0)};
    end else begin
      for (int k = 0; k < head; k++)
        expected_order = {expected_order, mk(order[k], 1'b1, k == head - 1,
                                             (k == head - 1) && (head < n))};
    end
  endtask

  // Advance the predictor by one accepted item.
  task automatic predict_item(input in_item_t it);
    int unsigned n;
    n = (vcount > VMAX) ? VMAX : vcount;
    case (op_t'(it.op))
      OP_ADD: begin
        if (it.src_vertex >= n || it.dst_vertex >= n || edge_cnt >= EMAX) begin
          dropped = 1'b1;
        end else begin
          graph_edges[edge_cnt] = {it.src_vertex, it.dst_vertex};
          edge_cnt++;
        end
      end
      OP_SORT: begin
        predict_sort();
        sorts_run++;
      end
      OP_CLEAR: begin
        edge_cnt = 0;
        dropped = 1'b0;
      end
      default: begin
      end
    endcase
  endtask

  initial begin
    forever #4 clk = ~clk;
  end

  // Driver: hold each item until accepted, then idle for send_gap, drawn at random.
  int send_gap = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        predict_item(in_data);
        items_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (send_enable && pending_items.size() > 0) begin
          in_data <= pending_items.pop_front();
          in_valid <= 1'b1;
          send_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each accepted result with the oldest expectation.
  int stall_left = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_order.size() == 0) begin
          report("unexpected", out_data, '0);
        end else begin
          out_item_t want;
          want = expected_order.pop_front();
          if (out_data.vertex !== want.vertex) report("vertex", out_data, want);
          if (out_data.vertex_valid !== want.vertex_valid) report("valid", out_data, want);
          if (out_data.last !== want.last) report("last", out_data, want);
          if (out_data.incomplete !== want.incomplete) report("incomplete", out_data, want);
          if (out_data.edges_dropped !== want.edges_dropped) report("dropped", out_data, want);
        end
      end
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        stall_left <= ($urandom_range(0, 2) == 0) ? $urandom_range(0, 4) : 0;
      end
    end
  end

  function automatic in_item_t item(input op_t op, input int s, input int d);
    in_item_t it;
    it.op = op;
    it.src_vertex = s[4:0];
    it.dst_vertex = d[4:0];
    return it;
  endfunction

  // Append one item to the send list.
  task automatic queue_item(input op_t op, input int s, input int d);
    pending_items = {pending_items, item(op, s, d)};
  endtask

  // Wait until sent, drained, and the back end has had time to settle.
  task automatic drain();
    send_enable = 1'b1;
    while (pending_items.size() > 0 || in_valid || expected_order.size() > 0)
      @(posedge clk);
    repeat (600) @(posedge clk);
  endtask

  task automatic set_count(input int c);
    @(posedge clk);
    cfg_vertex_count <= c[5:0];
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    vcount = c[5:0];
  endtask

  // Random graph: mostly forward (acyclic) edges, some back edges and junk.
  task automatic random_graph(input int n, input int edges);
    int s, d;
    queue_item(OP_CLEAR, $urandom, $urandom);
    for (int k = 0; k < edges; k++) begin
      s = $urandom_range(0, n - 1);
      d = $urandom_range(0, n - 1);
      case ($urandom_range(0, 9))
        0: s = $urandom_range(0, 31);
        1: d = $urandom_range(0, 31);
        2, 3: ;
        default: if (s > d) begin
          int t;
          t = s; s = d; d = t;
        end
      endcase
      queue_item(OP_ADD, s, d);
    end
    if ($urandom_range(0, 7) == 0) queue_item(OP_NONE, $urandom, $urandom);
    queue_item(OP_SORT, $urandom, $urandom);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: reset count, chain with extremes, self-loop, cycle, op 3.
    queue_item(OP_SORT, 0, 0);
    queue_item(OP_ADD, 31, 0);
    queue_item(OP_ADD, 0, 31);
    queue_item(OP_ADD, 5, 5);
    queue_item(OP_NONE, 31, 31);
    queue_item(OP_SORT, 31, 31);
    queue_item(OP_CLEAR, 0, 0);
    queue_item(OP_ADD, 2, 1);
    queue_item(OP_ADD, 1, 0);
    queue_item(OP_ADD, 3, 1);
    queue_item(OP_SORT, 0, 0);
    drain();

    // Small count: out-of-range edges drop, stale edges ignored, full cycle.
    set_count(3);
    queue_item(OP_ADD, 3, 0);
    queue_item(OP_ADD, 0, 1);
    queue_item(OP_ADD, 1, 2);
    queue_item(OP_ADD, 2, 0);
    queue_item(OP_SORT, 0, 0);
    drain();
    set_count(0);
    queue_item(OP_ADD, 0, 0);
    queue_item(OP_SORT, 0, 0);
    drain();
    set_count(1);
    queue_item(OP_CLEAR, 0, 0);
    queue_item(OP_SORT, 0, 0);
    drain();

    // Count above the vertex limit saturates.
    set_count(63);
    queue_item(OP_CLEAR, 0, 0);
    queue_item(OP_ADD, 31, 30);
    queue_item(OP_ADD, 30, 29);
    queue_item(OP_SORT, 0, 0);
    drain();

    // Random phases across several counts.
    for (int p = 0; p < 9; p++) begin
      int c;
      c = (p == 0) ? 32 : (p == 1) ? 2 : $urandom_range(1, 32);
      set_count(c);
      random_graph(c, $urandom_range(2, 12));
      if (p == 5) drain();
      else if (p % 4 == 3) begin
        random_graph(c, $urandom_range(0, 4));
        drain();
      end else drain();
    end

    $display("covered %0d items, %0d sorts, %0d result items", items_sent, sorts_run,
             results_seen);
    $display("counts from empty to saturated, drops, cycles, self-loops and stale edges");
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("timeout");
    $display("status: fail");
    $finish;
  end
endmodule
`default_nettype wire
